### sv/assert_macros.svh
// assertion helpers used by the monitor rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that a property holds on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// check that a property holds on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`endif

### sv/mthm_pkg.sv
// ----------------------------------------------------------------------------
// mthm_pkg
// shared types and constants of the threshold health monitor
// ----------------------------------------------------------------------------
package mthm_pkg;
  localparam int unsigned MaxMetricsDef = 16;
  localparam int unsigned CntW = 5;
  localparam logic [CntW-1:0] CntMax = 5'd31;

  typedef enum logic [2:0] {
    CMD_REGISTER = 3'd0,
    CMD_ENABLE   = 3'd1,
    CMD_BEGIN    = 3'd2,
    CMD_SAMPLE   = 3'd3,
    CMD_END      = 3'd4,
    CMD_HEALTH   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_INVALID   = 3'd1,
    ERR_FULL      = 3'd2,
    ERR_NOT_FOUND = 3'd3,
    ERR_STATE     = 3'd4
  } err_e;

  localparam logic [1:0] SevOk   = 2'd0;
  localparam logic [1:0] SevWarn = 2'd1;
  localparam logic [1:0] SevCrit = 2'd2;

  localparam logic [1:0] StUnsampled = 2'd0;
  localparam logic [1:0] StValid     = 2'd1;
  localparam logic [1:0] StDisabled  = 2'd2;
  localparam logic [1:0] StFailed    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WALK,
    ST_WALK_LAST,
    ST_OUT
  } state_e;

  // one table entry
  typedef struct packed {
    logic        dir;
    logic [31:0] warn;
    logic [31:0] crit;
    logic        en;
    logic [1:0]  sev;
    logic [1:0]  status;
    logic [31:0] lv_value;
    logic [1:0]  lv_sev;
  } entry_t;

  // one result word
  typedef struct packed {
    logic [31:0] reported_value;
    logic [4:0]  valid_total;
    logic [4:0]  enab_total;
    logic        healthy;
    logic [4:0]  fail_total;
    logic [4:0]  transitions_in_check;
    logic [1:0]  sample_status;
    logic [1:0]  prior_severity;
    logic [1:0]  severity;
    logic        performed;
    logic [3:0]  assigned_index;
    logic [2:0]  error_code;
  } result_t;

  function automatic logic s_lt(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [1:0] grade(logic dir, logic [31:0] w, logic [31:0] c,
                                       logic [31:0] v);
    logic [1:0] g;
    g = SevOk;
    if (!dir) begin
      if (!s_lt(v, c)) g = SevCrit;
      else if (!s_lt(v, w)) g = SevWarn;
    end else begin
      if (!s_lt(c, v)) g = SevCrit;
      else if (!s_lt(w, v)) g = SevWarn;
    end
    return g;
  endfunction

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] c);
    return (c == CntMax) ? c : c + 1'b1;
  endfunction
endpackage

### sv/mthm_table.sv
// ----------------------------------------------------------------------------
// mthm_table
// metric table memory, one write port, one registered read port
// ----------------------------------------------------------------------------
module mthm_table #(
  parameter int unsigned Depth = mthm_pkg::MaxMetricsDef,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  mthm_pkg::entry_t     wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output mthm_pkg::entry_t     rdata_o
);
  import mthm_pkg::*;

  entry_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### sv/metric_threshold_health_monitor.sv
// ----------------------------------------------------------------------------
// metric_threshold_health_monitor
// warn/critical threshold monitor over a table of metrics in block memory
// ----------------------------------------------------------------------------
// table commands: memory read, then modify and write back with the result registered
// health query walks the table entry by entry from entry 0
// throughput: one command in flight, input stalls until the word is taken
// reset: counts, check state and interval clear at once; table undefined until written
module metric_threshold_health_monitor #(
  parameter int unsigned MaxMetrics = mthm_pkg::MaxMetricsDef,
  localparam int unsigned AW = (MaxMetrics > 1) ? $clog2(MaxMetrics) : 1,
  localparam int unsigned NW = $clog2(MaxMetrics + 1)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config: check_interval
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [2:0] command, [6:3] entry index, [7] direction, [39:8] warn_level,
  // [71:40] critical_level, [72] enable_flag, [104:73] current time in ms,
  // [105] force_req, [137:106] sample_value, [138] collect_ok, rest zero
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] error_code, [6:3] assigned_index, [7] performed, [9:8] severity,
  // [11:10] prior severity, [13:12] sample_status, [18:14] transitions,
  // [23:19] failures, [24] healthy, [29:25] enabled metrics,
  // [34:30] validly sampled metrics, [66:35] reported_value, rest zero
  output logic [71:0]  m_axis_tdata
);
  import mthm_pkg::*;
  `include "assert_macros.svh"

  // input word fields
  logic [2:0]  in_cmd;
  logic [3:0]  in_idx;
  logic        in_dir, in_en, in_force, in_ok;
  logic [31:0] in_warn, in_crit, in_ts, in_val;
  assign in_cmd   = s_axis_tdata[2:0];
  assign in_idx   = s_axis_tdata[6:3];
  assign in_dir   = s_axis_tdata[7];
  assign in_warn  = s_axis_tdata[39:8];
  assign in_crit  = s_axis_tdata[71:40];
  assign in_en    = s_axis_tdata[72];
  assign in_ts    = s_axis_tdata[104:73];
  assign in_force = s_axis_tdata[105];
  assign in_val   = s_axis_tdata[137:106];
  assign in_ok    = s_axis_tdata[138];

  // captured command
  logic [2:0]  cmd_q;
  logic [3:0]  idx_q;
  logic        dir_q, en_q, force_q, ok_q;
  logic [31:0] warn_q, crit_q, ts_q, val_q;

  // control state
  state_e      state_q, state_d;
  logic [31:0] interval_q;
  logic [NW-1:0] reg_cnt_q, reg_cnt_d;
  logic        has_checked_q, has_checked_d;
  logic [31:0] last_time_q, last_time_d;
  logic        open_q, open_d;
  logic [CntW-1:0] trans_q, trans_d, fails_q, fails_d;
  result_t     res_q, res_d;

  // walk state for the health query
  logic [NW-1:0] walk_q, walk_d;
  logic [1:0]  worst_q, worst_d;
  logic        hlth_q, hlth_d;
  logic [CntW-1:0] nen_q, nen_d, nsam_q, nsam_d, nfail_q, nfail_d;

  // memory port
  logic        we;
  logic [AW-1:0] waddr, raddr;
  entry_t      wdata, rdata;

  mthm_table #(.Depth(MaxMetrics)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic in_acc, idx_ok;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == ST_OUT);
  // zero-extended compare keeps index check valid for any table size
  assign idx_ok = ({{(32-NW){1'b0}}, reg_cnt_q} > {28'd0, idx_q}) &&
                  ({28'd0, idx_q} < MaxMetrics);

  // read address: the addressed entry, entry 0 to start a walk, or the walk pointer
  always_comb begin
    if (state_q == ST_IDLE) begin
      if (in_cmd == CMD_HEALTH) raddr = '0;
      else raddr = AW'(in_idx);
    end else begin
      raddr = AW'(walk_q);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_HEALTH) begin
            if (reg_cnt_q == '0) state_d = ST_OUT;
            else if (reg_cnt_q == NW'(1)) state_d = ST_WALK_LAST;
            else state_d = ST_WALK;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: state_d = ST_OUT;
      ST_WALK: if (walk_q == reg_cnt_q - NW'(1)) state_d = ST_WALK_LAST;
      ST_WALK_LAST: state_d = ST_OUT;
      ST_OUT: if (m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic [1:0] prev, sev, st;
    logic wrap_lt;
    reg_cnt_d = reg_cnt_q;
    has_checked_d = has_checked_q;
    last_time_d = last_time_q;
    open_d = open_q;
    trans_d = trans_q;
    fails_d = fails_q;
    res_d = res_q;
    walk_d = walk_q;
    worst_d = worst_q;
    hlth_d = hlth_q;
    nen_d = nen_q;
    nsam_d = nsam_q;
    nfail_d = nfail_q;
    we = 1'b0;
    waddr = AW'(idx_q);
    wdata = rdata;
    prev = SevOk;
    sev = SevOk;
    st = StUnsampled;
    wrap_lt = (ts_q - last_time_q) < interval_q;
    case (state_q)
      ST_IDLE: begin
        walk_d = '0;
        if (in_acc) begin
          res_d = '0;
          worst_d = SevOk;
          hlth_d = 1'b1;
          nen_d = '0;
          nsam_d = '0;
          nfail_d = '0;
          if (reg_cnt_q > NW'(1)) walk_d = NW'(1);
        end
      end
      ST_READ: begin
        res_d = '0;
        case (cmd_q)
          CMD_REGISTER: begin
            if (open_q) res_d.error_code = ERR_STATE;
            else if (!dir_q ? !s_lt(warn_q, crit_q) : !s_lt(crit_q, warn_q))
              res_d.error_code = ERR_INVALID;
            else if ({{(32-NW){1'b0}}, reg_cnt_q} >= MaxMetrics)
              res_d.error_code = ERR_FULL;
            else begin
              we = 1'b1;
              waddr = AW'(reg_cnt_q);
              wdata = '{dir: dir_q, warn: warn_q, crit: crit_q, en: 1'b1,
                        sev: SevOk, status: StUnsampled, lv_value: '0,
                        lv_sev: SevOk};
              res_d.assigned_index = 4'(reg_cnt_q);
              reg_cnt_d = reg_cnt_q + NW'(1);
            end
          end
          CMD_ENABLE: begin
            if (open_q) res_d.error_code = ERR_STATE;
            else if (!idx_ok) res_d.error_code = ERR_NOT_FOUND;
            else begin
              we = 1'b1;
              wdata.en = en_q;
              wdata.sev = rdata.lv_sev;
              wdata.status = en_q ? StUnsampled : StDisabled;
              if (en_q) wdata.lv_sev = SevOk;
            end
          end
          CMD_BEGIN: begin
            if (open_q) res_d.error_code = ERR_STATE;
            else if (!(!force_q && has_checked_q && wrap_lt)) begin
              open_d = 1'b1;
              trans_d = '0;
              fails_d = '0;
              last_time_d = ts_q;
              has_checked_d = 1'b1;
              res_d.performed = 1'b1;
            end
          end
          CMD_SAMPLE: begin
            if (!open_q) res_d.error_code = ERR_STATE;
            else if (!idx_ok) res_d.error_code = ERR_NOT_FOUND;
            else if (!rdata.en || !ok_q) begin
              st = rdata.en ? StFailed : StDisabled;
              if (st == StFailed) fails_d = sat_inc(fails_q);
              we = 1'b1;
              wdata.sev = rdata.lv_sev;
              wdata.status = st;
              res_d.severity = rdata.lv_sev;
              res_d.prior_severity = rdata.lv_sev;
              res_d.sample_status = st;
              res_d.reported_value = rdata.lv_value;
            end else begin
              prev = (rdata.status == StValid) ? rdata.sev : SevOk;
              sev = grade(rdata.dir, rdata.warn, rdata.crit, val_q);
              if (sev != prev) trans_d = sat_inc(trans_q);
              we = 1'b1;
              wdata.sev = sev;
              wdata.status = StValid;
              wdata.lv_value = val_q;
              wdata.lv_sev = sev;
              res_d.severity = sev;
              res_d.prior_severity = prev;
              res_d.sample_status = StValid;
              res_d.reported_value = val_q;
            end
          end
          CMD_END: begin
            if (!open_q) res_d.error_code = ERR_STATE;
            else begin
              open_d = 1'b0;
              res_d.transitions_in_check = trans_q;
              res_d.fail_total = fails_q;
            end
          end
          default: res_d.error_code = ERR_INVALID;
        endcase
      end
      ST_WALK, ST_WALK_LAST: begin
        // rdata holds the entry addressed in the previous cycle
        if (rdata.en) begin
          nen_d = sat_inc(nen_q);
          if (rdata.status == StValid) begin
            nsam_d = sat_inc(nsam_q);
            if (rdata.sev > worst_q) worst_d = rdata.sev;
            if (rdata.sev != SevOk) hlth_d = 1'b0;
          end else begin
            if (rdata.status == StFailed) nfail_d = sat_inc(nfail_q);
            hlth_d = 1'b0;
          end
        end
        walk_d = walk_q + NW'(1);
      end
      ST_OUT: ;
      default: ;
    endcase
    if (state_q == ST_WALK_LAST || (state_q == ST_IDLE && in_acc && in_cmd == CMD_HEALTH
        && reg_cnt_q == '0)) begin
      res_d = '0;
      res_d.severity = worst_d;
      res_d.fail_total = nfail_d;
      res_d.healthy = hlth_d;
      res_d.enab_total = nen_d;
      res_d.valid_total = nsam_d;
    end
  end

  assign m_axis_tdata = {5'd0, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      interval_q <= '0;
      reg_cnt_q <= '0;
      has_checked_q <= 1'b0;
      last_time_q <= '0;
      open_q <= 1'b0;
      trans_q <= '0;
      fails_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) interval_q <= cfg_wdata_i;
      reg_cnt_q <= reg_cnt_d;
      has_checked_q <= has_checked_d;
      last_time_q <= last_time_d;
      open_q <= open_d;
      trans_q <= trans_d;
      fails_q <= fails_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    walk_q <= walk_d;
    worst_q <= worst_d;
    hlth_q <= hlth_d;
    nen_q <= nen_d;
    nsam_q <= nsam_d;
    nfail_q <= nfail_d;
    if (in_acc) begin
      cmd_q <= in_cmd;
      idx_q <= in_idx;
      dir_q <= in_dir;
      warn_q <= in_warn;
      crit_q <= in_crit;
      en_q <= in_en;
      ts_q <= in_ts;
      force_q <= in_force;
      val_q <= in_val;
      ok_q <= in_ok;
    end
  end

  `ASSERT_CLK(a_cnt_bound, clk_i, rst_ni, {{(32-NW){1'b0}}, reg_cnt_q} <= MaxMetrics)
  `ASSERT_CLK(a_read_to_out, clk_i, rst_ni, state_q == ST_READ |=> state_q == ST_OUT)
  `ASSERT_CLK(a_no_write_idle, clk_i, rst_ni, state_q == ST_IDLE |-> !we)
  `ASSERT_CLK(a_cnt_only_reg, clk_i, rst_ni,
              reg_cnt_q != $past(reg_cnt_q) |-> $past(state_q) == ST_READ)
endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives command words into the threshold health monitor, predicts every
// response word from a private copy of the metric table and compares them
// ----------------------------------------------------------------------------

class health_scoreboard;
  typedef struct packed {
    logic [2:0]  err;
    logic [3:0]  aidx;
    logic        perf;
    logic [1:0]  sev;
    logic [1:0]  psev;
    logic [1:0]  stat;
    logic [31:0] val;
    logic [4:0]  trans;
    logic [4:0]  fails;
    logic        hlth;
    logic [4:0]  nen;
    logic [4:0]  nsam;
  } resp_t;

  logic [31:0] interval;
  logic        m_dir[16];
  logic [31:0] m_warn[16];
  logic [31:0] m_crit[16];
  logic        m_en[16];
  logic [1:0]  m_sev[16];
  logic [1:0]  m_stat[16];
  logic [31:0] m_lval[16];
  logic [1:0]  m_lsev[16];
  int          nreg;
  bit          checked_once;
  logic [31:0] last_time;
  bit          open_chk;
  logic [4:0]  chk_trans;
  logic [4:0]  chk_fail;
  resp_t       pending[$];
  int          errors;

  function new();
    interval = 0; nreg = 0; checked_once = 0; last_time = 0;
    open_chk = 0; chk_trans = 0; chk_fail = 0; errors = 0;
  endfunction

  function logic [4:0] bump(logic [4:0] c);
    return (c == 5'd31) ? c : c + 5'd1;
  endfunction

  function logic [1:0] rate(int i, logic [31:0] v);
    logic [1:0] g;
    g = mthm_pkg::SevOk;
    if (!m_dir[i]) begin
      if ($signed(v) >= $signed(m_crit[i])) g = mthm_pkg::SevCrit;
      else if ($signed(v) >= $signed(m_warn[i])) g = mthm_pkg::SevWarn;
    end else begin
      if ($signed(v) <= $signed(m_crit[i])) g = mthm_pkg::SevCrit;
      else if ($signed(v) <= $signed(m_warn[i])) g = mthm_pkg::SevWarn;
    end
    return g;
  endfunction

  function void note_command(logic [143:0] w);
    resp_t r;
    logic [2:0] cmd;
    int idx;
    logic dir, en, frc, ok;
    logic [31:0] warn, crit, ts, v;
    logic [1:0] st, prv, sv;
    bit good;
    cmd = w[2:0]; idx = w[6:3]; dir = w[7]; warn = w[39:8]; crit = w[71:40];
    en = w[72]; ts = w[104:73]; frc = w[105]; v = w[137:106]; ok = w[138];
    r = '0;
    case (cmd)
      mthm_pkg::CMD_REGISTER: begin
        if (open_chk) r.err = mthm_pkg::ERR_STATE;
        else if (dir == 0 ? $signed(warn) >= $signed(crit) : $signed(crit) >= $signed(warn))
          r.err = mthm_pkg::ERR_INVALID;
        else if (nreg >= 16) r.err = mthm_pkg::ERR_FULL;
        else begin
          m_dir[nreg] = dir; m_warn[nreg] = warn; m_crit[nreg] = crit; m_en[nreg] = 1;
          m_sev[nreg] = 0; m_stat[nreg] = 0; m_lval[nreg] = 0; m_lsev[nreg] = 0;
          r.aidx = 4'(nreg); nreg++;
        end
      end
      mthm_pkg::CMD_ENABLE: begin
        if (open_chk) r.err = mthm_pkg::ERR_STATE;
        else if (idx >= nreg) r.err = mthm_pkg::ERR_NOT_FOUND;
        else begin
          m_en[idx] = en; m_sev[idx] = m_lsev[idx];
          m_stat[idx] = en ? mthm_pkg::StUnsampled : mthm_pkg::StDisabled;
          if (en) m_lsev[idx] = mthm_pkg::SevOk;
        end
      end
      mthm_pkg::CMD_BEGIN: begin
        if (open_chk) r.err = mthm_pkg::ERR_STATE;
        else if (frc || !checked_once || (ts - last_time) >= interval) begin
          open_chk = 1; chk_trans = 0; chk_fail = 0; last_time = ts;
          checked_once = 1; r.perf = 1;
        end
      end
      mthm_pkg::CMD_SAMPLE: begin
        if (!open_chk) r.err = mthm_pkg::ERR_STATE;
        else if (idx >= nreg) r.err = mthm_pkg::ERR_NOT_FOUND;
        else if (!m_en[idx] || !ok) begin
          st = m_en[idx] ? mthm_pkg::StFailed : mthm_pkg::StDisabled;
          if (st == mthm_pkg::StFailed) chk_fail = bump(chk_fail);
          m_sev[idx] = m_lsev[idx]; m_stat[idx] = st;
          r.sev = m_lsev[idx]; r.psev = m_lsev[idx]; r.stat = st; r.val = m_lval[idx];
        end else begin
          prv = (m_stat[idx] == mthm_pkg::StValid) ? m_sev[idx] : mthm_pkg::SevOk;
          sv = rate(idx, v);
          if (sv != prv) chk_trans = bump(chk_trans);
          m_sev[idx] = sv; m_stat[idx] = mthm_pkg::StValid;
          m_lval[idx] = v; m_lsev[idx] = sv;
          r.sev = sv; r.psev = prv; r.stat = mthm_pkg::StValid; r.val = v;
        end
      end
      mthm_pkg::CMD_END: begin
        if (!open_chk) r.err = mthm_pkg::ERR_STATE;
        else begin
          open_chk = 0; r.trans = chk_trans; r.fails = chk_fail;
        end
      end
      mthm_pkg::CMD_HEALTH: begin
        good = 1;
        for (int i = 0; i < nreg; i++) begin
          if (!m_en[i]) continue;
          r.nen = bump(r.nen);
          if (m_stat[i] == mthm_pkg::StValid) begin
            r.nsam = bump(r.nsam);
            if (m_sev[i] > r.sev) r.sev = m_sev[i];
            if (m_sev[i] != mthm_pkg::SevOk) good = 0;
          end else begin
            if (m_stat[i] == mthm_pkg::StFailed) r.fails = bump(r.fails);
            good = 0;
          end
        end
        r.hlth = good;
      end
      default: r.err = mthm_pkg::ERR_INVALID;
    endcase
    pending.push_back(r);
  endfunction

  function void check_result(logic [71:0] d);
    resp_t e, a;
    a.err = d[2:0]; a.aidx = d[6:3]; a.perf = d[7]; a.sev = d[9:8];
    a.psev = d[11:10]; a.stat = d[13:12]; a.trans = d[18:14]; a.fails = d[23:19];
    a.hlth = d[24]; a.nen = d[29:25]; a.nsam = d[34:30]; a.val = d[66:35];
    if (pending.size() == 0) begin
      $display("%0t unexpected word: expected none, actual %h", $time, d);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e.err !== a.err) report("error_code", e.err, a.err);
    if (e.aidx !== a.aidx) report("assigned_index", e.aidx, a.aidx);
    if (e.perf !== a.perf) report("performed", e.perf, a.perf);
    if (e.sev !== a.sev) report("severity", e.sev, a.sev);
    if (e.psev !== a.psev) report("prior severity", e.psev, a.psev);
    if (e.stat !== a.stat) report("sample_status", e.stat, a.stat);
    if (e.val !== a.val) report("reported_value", e.val, a.val);
    if (e.trans !== a.trans) report("transitions", e.trans, a.trans);
    if (e.fails !== a.fails) report("failures", e.fails, a.fails);
    if (e.hlth !== a.hlth) report("healthy", e.hlth, a.hlth);
    if (e.nen !== a.nen) report("enabled metrics", e.nen, a.nen);
    if (e.nsam !== a.nsam) report("valid metrics", e.nsam, a.nsam);
    if (d[71:67] !== 0) report("pad bits", 0, d[71:67]);
  endfunction

  function void report(string f, logic [31:0] e, logic [31:0] a);
    $display("%0t mismatch %s: expected %h, actual %h", $time, f, e, a);
    errors++;
  endfunction
endclass

module tb_top;
  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_we_i = 0;
  logic [31:0]  cfg_wdata_i = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [71:0]  m_axis_tdata;

  health_scoreboard sb = new();
  int send_idle = 0;  // percent of cycles the sender holds back
  int recv_idle = 0;  // percent of cycles the receiver stalls
  bit hold_off = 0;   // long receiver stall to back up the block
  int quiet = 0;
  int rr;             // register commands sent so far, capped at 16, for stimulus shaping

  always #6 clk_i = ~clk_i;

  metric_threshold_health_monitor dut (.*);

  // receiver: random stalls, plus the long hold-off
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  // watchdog: count cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // offer one command word and hold it until taken; valid drops in idle
  // cycles and in drain, the block is not ready right after a word
  task automatic send_word(logic [143:0] w);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_command(w);
    if (w[2:0] == mthm_pkg::CMD_REGISTER && rr < 16) rr++;
  endtask

  function automatic logic [143:0] pack_cmd(logic [2:0] cmd, logic [3:0] idx, logic dir,
      logic [31:0] warn, logic [31:0] crit, logic en, logic [31:0] ts, logic frc,
      logic [31:0] v, logic ok);
    return {5'd0, ok, v, frc, ts, en, crit, warn, dir, idx, cmd};
  endfunction

  // well-formed register: ordered thresholds for the direction
  task automatic add_metric(logic dir, logic [31:0] a, logic [31:0] b);
    logic [31:0] lo, hi;
    lo = ($signed(a) < $signed(b)) ? a : b;
    hi = ($signed(a) < $signed(b)) ? b : a;
    if (lo == hi) hi = lo + 1;
    if ($signed(hi) < $signed(lo)) begin lo = 32'h7fff_fffe; hi = 32'h7fff_ffff; end
    send_word(pack_cmd(mthm_pkg::CMD_REGISTER, $urandom, dir, dir ? hi : lo,
                       dir ? lo : hi, $urandom, $urandom, $urandom, $urandom, $urandom));
  endtask

  // random command mix, biased to full begin/sample/end check sequences
  task automatic random_traffic(int n);
    logic [31:0] base;
    int k;
    k = 0;
    while (k < n) begin
      case ($urandom_range(9))
        0: begin
          add_metric($urandom, $urandom_range(200) - 100, $urandom_range(200) - 100);
          k++;
        end
        1: begin
          send_word(pack_cmd($urandom_range(7), $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom));
          k++;
        end
        2: begin
          send_word(pack_cmd(mthm_pkg::CMD_ENABLE, $urandom_range(rr + 1), 0, 0, 0,
                             $urandom_range(3) != 0, 0, 0, 0, 0));
          k++;
        end
        default: begin
          base = $urandom;
          send_word(pack_cmd(mthm_pkg::CMD_BEGIN, 0, 0, 0, 0, 0, sb.last_time + base % 64,
                             $urandom_range(3) == 0, 0, 0));
          repeat ($urandom_range(1, 8)) begin
            send_word(pack_cmd(mthm_pkg::CMD_SAMPLE, $urandom_range(rr), 0, 0, 0, 0, 0, 0,
                               ($urandom_range(3) == 0) ? $urandom
                                                        : $urandom_range(240) - 120,
                               $urandom_range(4) != 0));
            k++;
          end
          if ($urandom_range(4) == 0)
            send_word(pack_cmd(mthm_pkg::CMD_HEALTH, 0, 0, 0, 0, 0, 0, 0, 0, 0));
          send_word(pack_cmd(mthm_pkg::CMD_END, 0, 0, 0, 0, 0, 0, 0, 0, 0));
          k += 2;
        end
      endcase
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic set_interval(logic [31:0] v);
    drain();
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    sb.interval = v;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  initial begin
    rr = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, errors and every command
    send_word(pack_cmd(mthm_pkg::CMD_HEALTH, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(pack_cmd(mthm_pkg::CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 5, 1));
    send_word(pack_cmd(mthm_pkg::CMD_END, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(pack_cmd(mthm_pkg::CMD_ENABLE, 15, 0, 0, 0, 1, 0, 0, 0, 0));
    send_word(pack_cmd(3'd6, 15, 1, '1, '1, 1, '1, 1, '1, 1));
    send_word(pack_cmd(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // equal and reversed levels are rejected
    send_word(pack_cmd(mthm_pkg::CMD_REGISTER, 0, 0, 10, 10, 0, 0, 0, 0, 0));
    send_word(pack_cmd(mthm_pkg::CMD_REGISTER, 0, 1, 5, 9, 0, 0, 0, 0, 0));
    add_metric(0, 32'h8000_0000, 32'h7fff_ffff);
    add_metric(1, 32'h8000_0000, 32'h7fff_ffff);
    add_metric(0, 10, 20);
    send_word(pack_cmd(mthm_pkg::CMD_BEGIN, 0, 0, 0, 0, 0, '1, 0, 0, 0));
    send_word(pack_cmd(mthm_pkg::CMD_BEGIN, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    send_word(pack_cmd(mthm_pkg::CMD_REGISTER, 0, 0, 1, 2, 0, 0, 0, 0, 0));
    send_word(pack_cmd(mthm_pkg::CMD_ENABLE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(pack_cmd(mthm_pkg::CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff, 1));
    send_word(pack_cmd(mthm_pkg::CMD_SAMPLE, 1, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 1));
    send_word(pack_cmd(mthm_pkg::CMD_SAMPLE, 2, 0, 0, 0, 0, 0, 0, 10, 1));
    send_word(pack_cmd(mthm_pkg::CMD_SAMPLE, 2, 0, 0, 0, 0, 0, 0, 20, 0));
    send_word(pack_cmd(mthm_pkg::CMD_SAMPLE, 9, 0, 0, 0, 0, 0, 0, 0, 1));
    send_word(pack_cmd(mthm_pkg::CMD_HEALTH, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(pack_cmd(mthm_pkg::CMD_END, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(pack_cmd(mthm_pkg::CMD_ENABLE, 2, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(pack_cmd(mthm_pkg::CMD_ENABLE, 2, 0, 0, 0, 1, 0, 0, 0, 0));

    // gated checks with a wrapping interval
    set_interval(32'd40);
    send_idle = 22; recv_idle = 75;
    random_traffic(200);

    // long receiver stall while commands keep coming
    drain();
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      random_traffic(20);
    join

    set_interval(32'hffff_ffff);
    send_idle = 75; recv_idle = 22;
    random_traffic(200);

    set_interval(32'd0);
    send_idle = 0; recv_idle = 0;
    random_traffic(180);
    // fill the table to exercise the full error
    repeat (18) add_metric($urandom, $urandom, $urandom);
    send_word(pack_cmd(mthm_pkg::CMD_END, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    repeat (18) add_metric($urandom, $urandom, $urandom);
    send_word(pack_cmd(mthm_pkg::CMD_HEALTH, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    drain();
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
